@@ rtl/hspd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package hspd_pkg;

    // Timer tick length in microseconds
    localparam int TICK_US = 10;

    localparam int TS_W     = 16;
    localparam int THRESH_W = 10;
    localparam int EDGE_W   = 7;

    // Edges in each part of the frame
    localparam logic [EDGE_W-1:0] RESP_EDGES  = EDGE_W'(3);
    localparam logic [EDGE_W-1:0] DATA_EDGES  = EDGE_W'(64);
    localparam logic [EDGE_W-1:0] CHECK_EDGES = EDGE_W'(16);

    // Event codes
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_TIMER = 2'd1;
    localparam logic [1:0] REQ_EDGE  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_SENSOR_TYPE  = 2'd0;
    localparam logic [1:0] CFG_CHECK_EN     = 2'd1;
    localparam logic [1:0] CFG_DATA_THRESH  = 2'd2;
    localparam logic [1:0] CFG_CRC_THRESH   = 2'd3;

    // Phase codes as reported on the result
    localparam logic [2:0] PHASE_IDLE    = 3'd0;
    localparam logic [2:0] PHASE_REQUEST = 3'd1;
    localparam logic [2:0] PHASE_WAIT    = 3'd2;
    localparam logic [2:0] PHASE_DATA    = 3'd3;
    localparam logic [2:0] PHASE_CHECK   = 3'd4;
    localparam logic [2:0] PHASE_OK      = 3'd5;
    localparam logic [2:0] PHASE_TIMEOUT = 3'd6;
    localparam logic [2:0] PHASE_CRCERR  = 3'd7;

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_REQUEST = 8'b0000_0010,
        ST_WAIT    = 8'b0000_0100,
        ST_DATA    = 8'b0000_1000,
        ST_CHECK   = 8'b0001_0000,
        ST_OK      = 8'b0010_0000,
        ST_TIMEOUT = 8'b0100_0000,
        ST_CRCERR  = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic [1:0]      req_type;
        logic [TS_W-1:0] timestamp;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  phase;
        logic        done_res;
        logic        drive_low;
        logic [15:0] temperature;
        logic [15:0] humidity;
    } out_item_t;

    typedef struct packed {
        logic                sensor_type;
        logic                checksum_enable;
        logic [THRESH_W-1:0] data_one_threshold_us;
        logic [THRESH_W-1:0] crc_one_threshold_us;
    } cfg_t;

    typedef struct packed {
        phase_t            phase;
        logic [EDGE_W-1:0] edge_count;
        logic [31:0]       data_shift;
        logic [7:0]        check_shift;
        logic [TS_W-1:0]   rise_time;
        logic [15:0]       temp_val;
        logic [15:0]       humid_val;
    } frame_state_t;

    function automatic logic [2:0] phase_code(input phase_t ph);
        logic [2:0] code;
        case (ph)
            ST_IDLE:    code = PHASE_IDLE;
            ST_REQUEST: code = PHASE_REQUEST;
            ST_WAIT:    code = PHASE_WAIT;
            ST_DATA:    code = PHASE_DATA;
            ST_CHECK:   code = PHASE_CHECK;
            ST_OK:      code = PHASE_OK;
            ST_TIMEOUT: code = PHASE_TIMEOUT;
            ST_CRCERR:  code = PHASE_CRCERR;
            default:    code = PHASE_IDLE;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

@@ rtl/hspd_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Next-state and result logic for one line event.
module hspd_core (
    input  var hspd_pkg::in_item_t     item,
    input  var hspd_pkg::cfg_t         cfg,
    input  var hspd_pkg::frame_state_t cur,
    output hspd_pkg::frame_state_t     nxt,
    output hspd_pkg::out_item_t        result
);
    import hspd_pkg::*;

    logic [TS_W-1:0]   ticks;
    logic [TS_W-1:0]   width_us;
    logic [THRESH_W-1:0] thresh;
    logic              bit_one;
    logic [EDGE_W-1:0] cnt_inc;
    logic [7:0]        check_new;
    logic [9:0]        byte_sum;
    logic              done;

    // High time in us, wrapped to 16 bits
    assign ticks    = item.timestamp - cur.rise_time;
    assign width_us = TS_W'((ticks - TS_W'(1)) * TS_W'(TICK_US) + TS_W'(1));
    assign thresh   = (cur.phase == ST_CHECK) ? cfg.crc_one_threshold_us
                                              : cfg.data_one_threshold_us;
    assign bit_one  = width_us > {{(TS_W-THRESH_W){1'b0}}, thresh};
    assign cnt_inc  = cur.edge_count + EDGE_W'(1);

    assign byte_sum = {2'b00, cur.data_shift[7:0]}   + {2'b00, cur.data_shift[15:8]}
                    + {2'b00, cur.data_shift[23:16]} + {2'b00, cur.data_shift[31:24]};

    always_comb
    begin
        nxt       = cur;
        done      = 1'b0;
        check_new = cur.check_shift;
        case (item.req_type)
            REQ_START:
            begin
                nxt.edge_count = '0;
                nxt.phase      = ST_REQUEST;
            end
            REQ_TIMER:
            begin
                if (cur.phase == ST_REQUEST)
                begin
                    nxt.edge_count = '0;
                    nxt.phase      = ST_WAIT;
                end
                else
                begin
                    nxt.phase = ST_TIMEOUT;
                    done      = 1'b1;
                end
            end
            REQ_EDGE:
            begin
                case (cur.phase)
                    ST_WAIT:
                    begin
                        nxt.edge_count = cnt_inc;
                        if (cnt_inc == RESP_EDGES)
                        begin
                            nxt.edge_count = '0;
                            nxt.data_shift = '0;
                            nxt.phase      = ST_DATA;
                        end
                    end
                    ST_DATA:
                    begin
                        nxt.edge_count = cnt_inc;
                        if (cnt_inc[0])
                        begin
                            nxt.rise_time  = item.timestamp;
                            nxt.data_shift = {cur.data_shift[30:0], 1'b0};
                        end
                        else if (bit_one)
                        begin
                            nxt.data_shift = {cur.data_shift[31:1], 1'b1};
                        end
                        if (cnt_inc == DATA_EDGES)
                        begin
                            nxt.edge_count  = '0;
                            nxt.check_shift = '0;
                            nxt.phase       = ST_CHECK;
                        end
                    end
                    ST_CHECK:
                    begin
                        nxt.edge_count = cnt_inc;
                        if (cfg.checksum_enable)
                        begin
                            if (cnt_inc[0])
                            begin
                                nxt.rise_time = item.timestamp;
                                check_new     = {cur.check_shift[6:0], 1'b0};
                            end
                            else if (bit_one)
                            begin
                                check_new = {cur.check_shift[7:1], 1'b1};
                            end
                        end
                        nxt.check_shift = check_new;
                        if (cnt_inc == CHECK_EDGES)
                        begin
                            done = 1'b1;
                            if (cfg.sensor_type)
                            begin
                                nxt.temp_val  = cur.data_shift[15:0];
                                nxt.humid_val = cur.data_shift[31:16];
                            end
                            else
                            begin
                                nxt.temp_val  = {8'h00, cur.data_shift[15:8]};
                                nxt.humid_val = {8'h00, cur.data_shift[31:24]};
                            end
                            if (cfg.checksum_enable && (check_new != byte_sum[7:0]))
                                nxt.phase = ST_CRCERR;
                            else
                                nxt.phase = ST_OK;
                        end
                    end
                    default:
                    begin
                        // idle, request or finished: edge ignored
                    end
                endcase
            end
            default:
            begin
                // unused event code: no change
            end
        endcase

        result.phase       = phase_code(nxt.phase);
        result.done_res    = done;
        result.drive_low   = (nxt.phase == ST_REQUEST);
        result.temperature = nxt.temp_val;
        result.humidity    = nxt.humid_val;
    end

endmodule

`default_nettype wire

@@ rtl/humidity_sensor_pulse_decoder_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Single-wire humidity/temperature sensor frame decoder. Each input
// transaction is one timestamped event (start request, timer expiry or line
// edge) and yields exactly one result transaction carrying the frame phase,
// a done flag, the line drive request and the last decoded raw temperature
// and humidity. One event is taken per clock while in_stall is low: events
// land in an input register, the next-state logic evaluates combinationally
// against the frame state, and the result is held in an output register.
// in_stall rises only while a result is held by out_stall in the output
// register and another event already sits in the input register.
// Configuration must be written through cfg_we/cfg_index/cfg_data only
// while the block is idle; the block itself does not enforce this.
module humidity_sensor_pulse_decoder_unit (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_stall,
    input  var hspd_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  wire                 out_stall,
    output hspd_pkg::out_item_t out_item,
    input  wire                 cfg_we,
    input  wire  [1:0]          cfg_index,
    input  wire  [hspd_pkg::THRESH_W-1:0] cfg_data
);
    import hspd_pkg::*;

    cfg_t         cfg_reg;
    frame_state_t state_reg;
    frame_state_t state_next;
    in_item_t     in_item_reg;
    logic         in_valid_reg;
    out_item_t    out_item_reg;
    out_item_t    result;
    logic         out_valid_reg;
    logic         out_free;
    logic         advance;

    // Output register can take a new result when empty or being drained
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sensor_type           <= 1'b0;
            cfg_reg.checksum_enable       <= 1'b1;
            cfg_reg.data_one_threshold_us <= THRESH_W'(50);
            cfg_reg.crc_one_threshold_us  <= THRESH_W'(40);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SENSOR_TYPE: cfg_reg.sensor_type           <= cfg_data[0];
                CFG_CHECK_EN:    cfg_reg.checksum_enable       <= cfg_data[0];
                CFG_DATA_THRESH: cfg_reg.data_one_threshold_us <= cfg_data;
                CFG_CRC_THRESH:  cfg_reg.crc_one_threshold_us  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Input register: loads whenever it is empty or moving on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_stall)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_item_reg <= in_item;
    end

    hspd_core u_core (
        .item   (in_item_reg),
        .cfg    (cfg_reg),
        .cur    (state_reg),
        .nxt    (state_next),
        .result (result)
    );

    // Frame state commits when the event moves into the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase       <= ST_IDLE;
            state_reg.edge_count  <= '0;
            state_reg.data_shift  <= '0;
            state_reg.check_shift <= '0;
            state_reg.rise_time   <= '0;
            state_reg.temp_val    <= '0;
            state_reg.humid_val   <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_item_reg <= result;
    end

endmodule

`default_nettype wire

@@ rtl/hspd_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module hspd_checker (
    input wire                 clk,
    input wire                 rst_n,
    input wire                 in_stall,
    input wire                 out_valid,
    input wire                 out_stall,
    input var hspd_pkg::out_item_t out_item
);
    import hspd_pkg::*;

    // Line is driven low exactly in the request phase
    a_drive_low: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.drive_low == (out_item.phase == PHASE_REQUEST)))
        else $error("drive_low does not match phase");

    // A finished frame reports a terminal phase
    a_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.done_res) |->
            (out_item.phase == PHASE_OK || out_item.phase == PHASE_TIMEOUT ||
             out_item.phase == PHASE_CRCERR))
        else $error("done_res with non-terminal phase");

    // Input backpressure only comes from a held result
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("in_stall without output backpressure");

    // A stalled result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_item)))
        else $error("stalled result changed");

endmodule

bind humidity_sensor_pulse_decoder_unit hspd_checker u_hspd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);

`default_nettype wire
